// File: rtl/tcp_flow_loss_classifier_unit_defines.svh
// Assertion macros for the TCP flow loss classifier.
// Used by the top level only; expands to nothing under SYNTHESIS.
`ifndef TCP_FLOW_LOSS_CLASSIFIER_UNIT_DEFINES_SVH
`define TCP_FLOW_LOSS_CLASSIFIER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TFL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tfl assertion failed");
`define TFL_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tfl assertion failed");
`else
`define TFL_ASSERT(label, prop)
`define TFL_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: rtl/tfl_pkg.sv
// Shared types and constants of the TCP flow loss classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tfl_pkg;

   localparam int HOLE_EVENT_LIMIT = 63;
   localparam int HOLE_W = $clog2(HOLE_EVENT_LIMIT + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_THRESHOLD     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EARLY_PACKET_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STALL_TIME_US      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REORDER_WINDOW_US  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_RESET_US       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIGHT_SEGMENTS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REORDER_SEGMENTS   = 3'd6;

   localparam logic [31:0] RST_JUMP_THRESHOLD     = 32'd22222;
   localparam logic [7:0]  RST_EARLY_PACKET_LIMIT = 8'd7;
   localparam logic [47:0] RST_STALL_TIME_US      = 48'd1000000;
   localparam logic [47:0] RST_REORDER_WINDOW_US  = 48'd200000;
   localparam logic [47:0] RST_GAP_RESET_US       = 48'd3600000000;
   localparam logic [7:0]  RST_FLIGHT_SEGMENTS    = 8'd4;
   localparam logic [7:0]  RST_REORDER_SEGMENTS   = 8'd3;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [1:0] CLASS_IN_ORDER = 2'd0;
   localparam logic [1:0] CLASS_HOLE     = 2'd1;
   localparam logic [1:0] CLASS_EARLY    = 2'd2;

   typedef enum logic [2:0] {
      EV_MAYBE_HOLE   = 3'd0,
      EV_HOLE         = 3'd1,
      EV_FLIGHT       = 3'd2,
      EV_OUT_OF_ORDER = 3'd3,
      EV_COUNT        = 3'd4
   } ev_kind_type;

   typedef enum logic [2:0] {
      P_FLUSH    = 3'd0,
      P_NEW      = 3'd1,
      P_IN_ORDER = 3'd2,
      P_HOLE     = 3'd3,
      P_EARLY_OK = 3'd4,
      P_EARLY_EV = 3'd5,
      P_OTHER    = 3'd6
   } path_type;

   typedef struct packed {
      logic        load;
      logic        calc1;
      logic        calc2;
      logic        div_start;
      logic        div_step;
      logic        div_fix;
      logic        emit;
      ev_kind_type ev_kind;
      logic        ev_last;
      logic        hole_adv;
      logic        commit;
      path_type    path;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic same;
      logic cnt_nz;
      logic seen;
      logic in_order;
      logic stall_hit;
      logic d_pos;
      logic sf_le_pb;
      logic early_ok;
      logic g_nz;
      logic div_done;
      logic flight;
      logic hole_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/tfl_channels.sv
// Valid/ready channel interfaces: packet records in, events out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface tfl_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] flow_key;
   logic [31:0] seq_begin;
   logic [31:0] seq_finish;
   logic [15:0] payload_len;
   logic [31:0] ack_number;
   logic [47:0] arrival_us;
   modport source (output valid, op, flow_key, seq_begin, seq_finish, payload_len,
                   ack_number, arrival_us, input ready);
   modport sink (input valid, op, flow_key, seq_begin, seq_finish, payload_len,
                 ack_number, arrival_us, output ready);
endinterface

interface tfl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [31:0] event_flow;
   logic [32:0] event_seq;
   logic [47:0] event_time_us;
   logic [31:0] event_count;
   logic        last_event;
   modport source (output valid, event_kind, event_flow, event_seq, event_time_us,
                   event_count, last_event, input ready);
   modport sink (input valid, event_kind, event_flow, event_seq, event_time_us,
                 event_count, last_event, output ready);
endinterface
`default_nettype wire

// File: rtl/tcp_flow_loss_classifier_unit.sv
// TCP flow loss classifier: top level joining controller and datapath.
// Depends on tfl_pkg, tfl_channels, tfl_controller, tfl_datapath and the defines header.
//
// Use: packet records (op 0) or an end-of-trace flush (op 1) enter on req_chan;
// events leave on rsp_chan, last_event marking the final event of a word. A word
// that causes no event produces nothing on rsp_chan.
// Sequence: one word at a time. A plain word passes latch, two compare stages,
// classify and commit from acceptance to ready again, plus an emit step for its
// single event. A hole runs a bit-serial divide of the gap and a fix step, then
// emits up to 63 hole events and, for a wide hole, a whole-flight event.
// The event register parts the two sides: the block returns to accept the next
// word while its last event still waits to be taken.
// Stall: while rsp_chan.ready is low and an event is held, emission waits; the
// flow state is committed only after the final event is loaded.
// Reset (synchronous, active high): configuration registers return to their
// defaults, flow state clears and no event is pending. Configuration writes on
// csr_* take effect at once and are meant for idle periods only.
`timescale 1ns / 1ps
`default_nettype none
`include "tcp_flow_loss_classifier_unit_defines.svh"
module tcp_flow_loss_classifier_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tfl_req_if.sink                             req_chan,
   tfl_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [tfl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tfl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tfl_pkg::cmd_type    dp_cmd;
   tfl_pkg::status_type dp_st;

   tfl_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (dp_st),
      .cmd       (dp_cmd)
   );

   tfl_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .in_op             (req_chan.op),
      .in_flow_key       (req_chan.flow_key),
      .in_seq_begin      (req_chan.seq_begin),
      .in_seq_finish     (req_chan.seq_finish),
      .in_payload_len    (req_chan.payload_len),
      .in_ack_number     (req_chan.ack_number),
      .in_arrival_us     (req_chan.arrival_us),
      .cmd               (dp_cmd),
      .st                (dp_st),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_event_kind    (rsp_chan.event_kind),
      .rsp_event_flow    (rsp_chan.event_flow),
      .rsp_event_seq     (rsp_chan.event_seq),
      .rsp_event_time_us (rsp_chan.event_time_us),
      .rsp_event_count   (rsp_chan.event_count),
      .rsp_last_event    (rsp_chan.last_event)
   );

   // one word in flight: ready drops straight after acceptance
   `TFL_ASSERT_NEXT(a_ready_drops, req_chan.valid && req_chan.ready, !req_chan.ready)
   // an event is only loaded when the event register can take it
   `TFL_ASSERT(a_emit_free, dp_cmd.emit |-> dp_st.out_free)
   // hole walk only runs with a non-zero segment guess
   `TFL_ASSERT(a_hole_guess, dp_cmd.hole_adv |-> dp_st.g_nz)

endmodule
`default_nettype wire

// File: rtl/tfl_datapath.sv
// Datapath: config registers, flow state, compares, hole divider, event register.
// Depends on tfl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfl_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [tfl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tfl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             in_op,
   input  wire logic [31:0]                      in_flow_key,
   input  wire logic [31:0]                      in_seq_begin,
   input  wire logic [31:0]                      in_seq_finish,
   input  wire logic [15:0]                      in_payload_len,
   input  wire logic [31:0]                      in_ack_number,
   input  wire logic [47:0]                      in_arrival_us,
   input  wire tfl_pkg::cmd_type                 cmd,
   output tfl_pkg::status_type                   st,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output logic [2:0]                            rsp_event_kind,
   output logic [31:0]                           rsp_event_flow,
   output logic [32:0]                           rsp_event_seq,
   output logic [47:0]                           rsp_event_time_us,
   output logic [31:0]                           rsp_event_count,
   output logic                                  rsp_last_event
);

   // config
   logic [31:0] jt_ff;
   logic [7:0]  epl_ff, fs_ff, rs_ff;
   logic [47:0] stall_ff, rw_ff, gr_ff;

   // flow state
   logic        seen_ff;
   logic [31:0] pflow_ff, pb_ff, pe_ff, total_ff, pack_ff;
   logic [15:0] guess_ff;
   logic [47:0] lft_ff, lat_ff;
   logic [1:0]  class_ff;

   // latched word
   logic        op_ff;
   logic [31:0] key_ff, sb_ff, sf_ff, ack_ff;
   logic [15:0] plen_ff;
   logic [47:0] tm_ff;

   // first compare stage
   logic signed [48:0] raw_ff;
   logic signed [32:0] d_ff, dpesf_ff;
   logic [15:0] gnew_ff;
   logic same_ff, pe_gt_jt_ff, tot_le_ff, ack_eq_ff, sf_le_pb_ff, eq_ff;

   // second compare stage
   logic stall_hit_ff, d_gt_jt_ff, d_lt_jt_ff, d_pos_ff, rw_ok_ff, reorder_ff;

   // divider and hole walk
   logic [16:0]          rem_ff;
   logic [31:0]          q_ff, n_ff;
   logic [tfl_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic                 flight_ff;
   logic [tfl_pkg::HOLE_W-1:0] lim_ff, hole_idx_ff;
   logic [32:0]          acc_ff;

   // event register
   logic        out_valid_ff;
   tfl_pkg::ev_kind_type out_kind_ff;
   logic [31:0] out_flow_ff, out_count_ff;
   logic [32:0] out_seq_ff;
   logic [47:0] out_time_ff;
   logic        out_last_ff;

   logic [16:0] div_t;
   logic [16:0] div_sub;
   logic        div_ge;
   logic [23:0] prod;
   logic [31:0] total_bump;
   logic signed [48:0] raw_in;
   logic raw_lt_gr;

   assign div_t   = {rem_ff[15:0], q_ff[31]};
   assign div_sub = div_t - {1'b0, gnew_ff};
   assign div_ge  = div_t >= {1'b0, gnew_ff};
   assign prod    = gnew_ff * rs_ff;
   assign total_bump = (total_ff == 32'hFFFF_FFFF) ? total_ff : total_ff + 32'd1;
   assign raw_in  = $signed({1'b0, tm_ff}) - $signed({1'b0, lft_ff});
   assign raw_lt_gr = raw_ff < $signed({1'b0, gr_ff});

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         jt_ff    <= tfl_pkg::RST_JUMP_THRESHOLD;
         epl_ff   <= tfl_pkg::RST_EARLY_PACKET_LIMIT;
         stall_ff <= tfl_pkg::RST_STALL_TIME_US;
         rw_ff    <= tfl_pkg::RST_REORDER_WINDOW_US;
         gr_ff    <= tfl_pkg::RST_GAP_RESET_US;
         fs_ff    <= tfl_pkg::RST_FLIGHT_SEGMENTS;
         rs_ff    <= tfl_pkg::RST_REORDER_SEGMENTS;
      end else if (csr_we) begin
         unique case (csr_index)
            tfl_pkg::CSR_JUMP_THRESHOLD:     jt_ff    <= csr_wdata[31:0];
            tfl_pkg::CSR_EARLY_PACKET_LIMIT: epl_ff   <= csr_wdata[7:0];
            tfl_pkg::CSR_STALL_TIME_US:      stall_ff <= csr_wdata;
            tfl_pkg::CSR_REORDER_WINDOW_US:  rw_ff    <= csr_wdata;
            tfl_pkg::CSR_GAP_RESET_US:       gr_ff    <= csr_wdata;
            tfl_pkg::CSR_FLIGHT_SEGMENTS:    fs_ff    <= csr_wdata[7:0];
            tfl_pkg::CSR_REORDER_SEGMENTS:   rs_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input latch and compare stages
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= in_op;
         key_ff  <= in_flow_key;
         sb_ff   <= in_seq_begin;
         sf_ff   <= in_seq_finish;
         plen_ff <= in_payload_len;
         ack_ff  <= in_ack_number;
         tm_ff   <= in_arrival_us;
      end
      if (cmd.calc1) begin
         raw_ff      <= raw_in;
         d_ff        <= $signed({1'b0, sb_ff}) - $signed({1'b0, pe_ff});
         dpesf_ff    <= $signed({1'b0, pe_ff}) - $signed({1'b0, sf_ff});
         gnew_ff     <= (plen_ff > guess_ff) ? plen_ff : guess_ff;
         same_ff     <= seen_ff && (key_ff == pflow_ff);
         pe_gt_jt_ff <= pe_ff > jt_ff;
         tot_le_ff   <= total_ff <= {24'd0, epl_ff};
         ack_eq_ff   <= ack_ff == pack_ff;
         sf_le_pb_ff <= sf_ff <= pb_ff;
         eq_ff       <= sb_ff == pe_ff;
      end
      if (cmd.calc2) begin
         // gaps at or above the reset limit count as zero
         stall_hit_ff <= raw_lt_gr ? (raw_ff >= $signed({1'b0, stall_ff})) :
                                     (stall_ff == 48'd0);
         d_gt_jt_ff <= d_ff > $signed({1'b0, jt_ff});
         d_lt_jt_ff <= d_ff < $signed({1'b0, jt_ff});
         d_pos_ff   <= d_ff > 33'sd0;
         rw_ok_ff   <= raw_ff < $signed({1'b0, rw_ff});
         reorder_ff <= dpesf_ff < $signed({9'd0, prod});
      end
   end

   // restoring divide of the gap by the segment guess, one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff      <= 17'd0;
         q_ff        <= d_ff[31:0];
         div_cnt_ff  <= '0;
         hole_idx_ff <= '0;
         acc_ff      <= {1'b0, pe_ff};
      end else if (cmd.div_step) begin
         rem_ff     <= div_ge ? div_sub : div_t;
         q_ff       <= {q_ff[30:0], div_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end else if (cmd.hole_adv) begin
         hole_idx_ff <= hole_idx_ff + 1'b1;
         acc_ff      <= acc_ff + {17'd0, gnew_ff};
      end
      if (cmd.div_fix) begin
         n_ff      <= q_ff + {31'd0, (rem_ff != 17'd0)};
         flight_ff <= q_ff >= {24'd0, fs_ff};
         lim_ff    <= (q_ff + {31'd0, (rem_ff != 17'd0)} < 32'(tfl_pkg::HOLE_EVENT_LIMIT)) ?
                      tfl_pkg::HOLE_W'(q_ff + {31'd0, (rem_ff != 17'd0)}) :
                      tfl_pkg::HOLE_W'(tfl_pkg::HOLE_EVENT_LIMIT);
      end
   end

   // flow state update at the end of a word
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         pflow_ff <= '0;
         pb_ff    <= '0;
         pe_ff    <= '0;
         guess_ff <= '0;
         total_ff <= '0;
         lft_ff   <= '0;
         lat_ff   <= '0;
         pack_ff  <= '0;
         class_ff <= tfl_pkg::CLASS_IN_ORDER;
      end else if (cmd.commit) begin
         unique case (cmd.path)
            tfl_pkg::P_FLUSH: begin
               seen_ff  <= 1'b0;
               pflow_ff <= '0;
               pb_ff    <= '0;
               pe_ff    <= '0;
               guess_ff <= '0;
               total_ff <= '0;
               lft_ff   <= '0;
               lat_ff   <= '0;
               pack_ff  <= '0;
               class_ff <= tfl_pkg::CLASS_IN_ORDER;
            end
            tfl_pkg::P_NEW: begin
               seen_ff  <= 1'b1;
               pflow_ff <= key_ff;
               pb_ff    <= sb_ff;
               pe_ff    <= sf_ff;
               total_ff <= 32'd1;
               guess_ff <= plen_ff;
               class_ff <= tfl_pkg::CLASS_IN_ORDER;
               lat_ff   <= tm_ff;
               pack_ff  <= ack_ff;
            end
            tfl_pkg::P_IN_ORDER: begin
               total_ff <= total_bump;
               if (d_lt_jt_ff) begin
                  pb_ff <= sb_ff;
                  pe_ff <= sf_ff;
               end
               class_ff <= tfl_pkg::CLASS_IN_ORDER;
               guess_ff <= gnew_ff;
               lft_ff   <= tm_ff;
               lat_ff   <= tm_ff;
               pack_ff  <= ack_ff;
            end
            tfl_pkg::P_HOLE: begin
               total_ff <= total_bump;
               pb_ff    <= sb_ff;
               pe_ff    <= sf_ff;
               class_ff <= tfl_pkg::CLASS_HOLE;
               guess_ff <= gnew_ff;
               lft_ff   <= tm_ff;
               lat_ff   <= tm_ff;
               pack_ff  <= ack_ff;
            end
            tfl_pkg::P_EARLY_OK: begin
               total_ff <= total_bump;
               class_ff <= tfl_pkg::CLASS_EARLY;
               guess_ff <= gnew_ff;
               lft_ff   <= tm_ff;
               lat_ff   <= tm_ff;
               pack_ff  <= ack_ff;
            end
            tfl_pkg::P_EARLY_EV: begin
               class_ff <= tfl_pkg::CLASS_EARLY;
               guess_ff <= gnew_ff;
               lft_ff   <= tm_ff;
               lat_ff   <= tm_ff;
               pack_ff  <= ack_ff;
            end
            tfl_pkg::P_OTHER: begin
               guess_ff <= gnew_ff;
               lft_ff   <= tm_ff;
               lat_ff   <= tm_ff;
               pack_ff  <= ack_ff;
            end
            default: ;
         endcase
      end
   end

   // event register, fields taken from the state still unchanged
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_kind_ff <= cmd.ev_kind;
         out_last_ff <= cmd.ev_last;
         unique case (cmd.ev_kind)
            tfl_pkg::EV_MAYBE_HOLE: begin
               out_flow_ff  <= key_ff;
               out_seq_ff   <= {1'b0, pe_ff};
               out_time_ff  <= lat_ff;
               out_count_ff <= '0;
            end
            tfl_pkg::EV_HOLE: begin
               out_flow_ff  <= key_ff;
               out_seq_ff   <= acc_ff;
               out_time_ff  <= lat_ff;
               out_count_ff <= '0;
            end
            tfl_pkg::EV_FLIGHT: begin
               out_flow_ff  <= key_ff;
               out_seq_ff   <= {1'b0, sb_ff};
               out_time_ff  <= tm_ff;
               out_count_ff <= n_ff;
            end
            tfl_pkg::EV_OUT_OF_ORDER: begin
               out_flow_ff  <= key_ff;
               out_seq_ff   <= {1'b0, sb_ff};
               out_time_ff  <= tm_ff;
               out_count_ff <= '0;
            end
            default: begin
               out_flow_ff  <= pflow_ff;
               out_seq_ff   <= '0;
               out_time_ff  <= '0;
               out_count_ff <= total_ff;
            end
         endcase
      end
   end

   always_comb begin
      st.op        = op_ff;
      st.same      = same_ff;
      st.cnt_nz    = total_ff != 32'd0;
      st.seen      = seen_ff;
      st.in_order  = eq_ff || (pe_gt_jt_ff && tot_le_ff) || d_gt_jt_ff;
      st.stall_hit = stall_hit_ff && ack_eq_ff;
      st.d_pos     = d_pos_ff;
      st.sf_le_pb  = sf_le_pb_ff;
      st.early_ok  = rw_ok_ff && (class_ff != tfl_pkg::CLASS_EARLY) && reorder_ff;
      st.g_nz      = gnew_ff != 16'd0;
      st.div_done  = div_cnt_ff == tfl_pkg::DIV_CNT_W'(tfl_pkg::DIV_STEPS - 1);
      st.flight    = flight_ff;
      st.hole_last = hole_idx_ff == (lim_ff - 1'b1);
      st.out_free  = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_kind    = out_kind_ff;
   assign rsp_event_flow    = out_flow_ff;
   assign rsp_event_seq     = out_seq_ff;
   assign rsp_event_time_us = out_time_ff;
   assign rsp_event_count   = out_count_ff;
   assign rsp_last_event    = out_last_ff;

endmodule
`default_nettype wire

// File: rtl/tfl_controller.sv
// Controller: sequences compare, classify, divide, event emission and commit.
// Depends on tfl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfl_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire tfl_pkg::status_type st,
   output tfl_pkg::cmd_type         cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_CALC1  = 10'b00_0000_0010,
      S_CALC2  = 10'b00_0000_0100,
      S_DECIDE = 10'b00_0000_1000,
      S_DIVIDE = 10'b00_0001_0000,
      S_FIX    = 10'b00_0010_0000,
      S_HOLES  = 10'b00_0100_0000,
      S_FLIGHT = 10'b00_1000_0000,
      S_EMIT   = 10'b01_0000_0000,
      S_COMMIT = 10'b10_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   tfl_pkg::path_type    path_ff, path_in;
   tfl_pkg::ev_kind_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         path_ff  <= tfl_pkg::P_OTHER;
         kind_ff  <= tfl_pkg::EV_COUNT;
      end else begin
         state_ff <= state_in;
         path_ff  <= path_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      path_in   = path_ff;
      kind_in   = kind_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.path    = path_ff;
      cmd.ev_kind = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid) state_in = S_CALC1;
         end
         S_CALC1: begin
            cmd.calc1 = 1'b1;
            state_in  = S_CALC2;
         end
         S_CALC2: begin
            cmd.calc2 = 1'b1;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_COMMIT;
            kind_in  = tfl_pkg::EV_COUNT;
            priority if (st.op) begin
               path_in  = tfl_pkg::P_FLUSH;
               state_in = S_EMIT;
            end else if (!st.same) begin
               path_in = tfl_pkg::P_NEW;
               if (st.seen && st.cnt_nz) state_in = S_EMIT;
            end else if (st.in_order) begin
               path_in = tfl_pkg::P_IN_ORDER;
               kind_in = tfl_pkg::EV_MAYBE_HOLE;
               if (st.stall_hit) state_in = S_EMIT;
            end else if (st.d_pos) begin
               path_in = tfl_pkg::P_HOLE;
               if (st.g_nz) begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIVIDE;
               end
            end else if (st.sf_le_pb) begin
               if (st.early_ok) begin
                  path_in = tfl_pkg::P_EARLY_OK;
               end else begin
                  path_in  = tfl_pkg::P_EARLY_EV;
                  kind_in  = tfl_pkg::EV_OUT_OF_ORDER;
                  state_in = S_EMIT;
               end
            end else begin
               path_in = tfl_pkg::P_OTHER;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (st.div_done) state_in = S_FIX;
         end
         S_FIX: begin
            cmd.div_fix = 1'b1;
            state_in    = S_HOLES;
         end
         S_HOLES: begin
            cmd.ev_kind  = tfl_pkg::EV_HOLE;
            cmd.ev_last  = st.hole_last && !st.flight;
            cmd.emit     = st.out_free;
            cmd.hole_adv = st.out_free;
            if (st.out_free && st.hole_last) state_in = st.flight ? S_FLIGHT : S_COMMIT;
         end
         S_FLIGHT: begin
            cmd.ev_kind = tfl_pkg::EV_FLIGHT;
            cmd.ev_last = 1'b1;
            cmd.emit    = st.out_free;
            if (st.out_free) state_in = S_COMMIT;
         end
         S_EMIT: begin
            cmd.ev_last = 1'b1;
            cmd.emit    = st.out_free;
            if (st.out_free) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: test/tfl_flow_checker.sv
// Watches the packet and event channels of the flow loss classifier, predicts each
// event from the accepted words and compares in order. Depends on tfl_pkg, tfl_channels.
`timescale 1ns / 1ps
`default_nettype none
module tfl_flow_checker
   import tfl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   tfl_req_if                         req,
   tfl_rsp_if                         rsp,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending,
   output int                         words_seen,
   output int                         events_seen
);

   typedef struct packed {
      ev_kind_type kind;
      logic [31:0] flow;
      logic [32:0] seq;
      logic [47:0] t_us;
      logic [31:0] count;
      logic        last;
   } flow_event_type;

   flow_event_type expected_events[$];

   // register copies
   logic [31:0] jump_thr;
   logic [7:0]  early_lim, flight_segs, reorder_segs;
   logic [47:0] stall_us, reorder_us, gap_reset;

   // flow tracking
   bit          have_flow;
   logic [31:0] cur_flow, last_ack, pkt_total;
   logic [32:0] seg_begin, seg_end;
   logic [15:0] seg_guess;
   logic [47:0] flow_time, any_time;
   logic [1:0]  last_kind;

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t check: %s got %0h want %0h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic void forget_flow();
      have_flow = 0; cur_flow = '0; seg_begin = '0; seg_end = '0; seg_guess = '0;
      pkt_total = '0; flow_time = '0; any_time = '0; last_ack = '0;
      last_kind = CLASS_IN_ORDER;
   endfunction

   function automatic void add_event(ev_kind_type kind, logic [31:0] flow, longint seq,
                                     logic [47:0] t_us, longint count);
      flow_event_type e;
      e.kind = kind; e.flow = flow; e.seq = seq[32:0]; e.t_us = t_us;
      e.count = count[31:0]; e.last = 1'b0;
      expected_events.push_back(e);
   endfunction

   function automatic void bump_total();
      if (pkt_total != 32'hFFFF_FFFF) pkt_total++;
   endfunction

   function automatic void classify_word(logic op, logic [31:0] key, logic [31:0] sb_in,
                                         logic [31:0] sf_in, logic [15:0] plen,
                                         logic [31:0] ack, logic [47:0] tm);
      longint sb, sf, pb, pe, raw, gap, jt, g, diff, n, lim;
      int start;
      flow_event_type tail;
      start = expected_events.size();
      sb = longint'(sb_in);
      sf = longint'(sf_in);
      if (op) begin
         // flush: count for whatever flow is held, even zero, then clear
         add_event(EV_COUNT, cur_flow, 0, '0, longint'(pkt_total));
         forget_flow();
      end else begin
         if (have_flow && key == cur_flow) begin
            pb  = longint'(seg_begin);
            pe  = longint'(seg_end);
            raw = longint'(tm) - longint'(flow_time);
            gap = (raw < longint'(gap_reset)) ? raw : 0;
            jt  = longint'(jump_thr);
            if (plen > seg_guess) seg_guess = plen;
            if (sb == pe || (pe > jt && pkt_total <= early_lim) || (sb - pe) > jt) begin
               if (gap >= longint'(stall_us) && ack == last_ack)
                  add_event(EV_MAYBE_HOLE, key, longint'(seg_end), any_time, 0);
               bump_total();
               if ((sb - pe) < jt) begin
                  seg_begin = sb[32:0];
                  seg_end   = sf[32:0];
               end
               last_kind = CLASS_IN_ORDER;
            end else if (sb > pe) begin
               g = longint'(seg_guess);
               if (g > 0) begin
                  diff = sb - pe;
                  n    = (diff + g - 1) / g;
                  lim  = (n < HOLE_EVENT_LIMIT) ? n : HOLE_EVENT_LIMIT;
                  for (longint i = 0; i < lim; i++)
                     add_event(EV_HOLE, key, pe + i * g, any_time, 0);
                  if ((diff / g) >= longint'(flight_segs))
                     add_event(EV_FLIGHT, key, sb, tm, n);
               end
               bump_total();
               seg_begin = sb[32:0];
               seg_end   = sf[32:0];
               last_kind = CLASS_HOLE;
            end else if (sf <= pb) begin
               if (raw < longint'(reorder_us) && last_kind != CLASS_EARLY &&
                   (pe - sf) < longint'(seg_guess) * longint'(reorder_segs))
                  bump_total();
               else
                  add_event(EV_OUT_OF_ORDER, key, sb, tm, 0);
               last_kind = CLASS_EARLY;
            end
            flow_time = tm;
         end else begin
            if (have_flow && pkt_total != 0)
               add_event(EV_COUNT, cur_flow, 0, '0, longint'(pkt_total));
            have_flow = 1;
            cur_flow  = key;
            seg_begin = sb[32:0];
            seg_end   = sf[32:0];
            pkt_total = 32'd1;
            seg_guess = plen;
            last_kind = CLASS_IN_ORDER;
         end
         any_time = tm;
         last_ack = ack;
      end
      if (expected_events.size() > start) begin
         tail = expected_events.pop_back();
         tail.last = 1'b1;
         expected_events.push_back(tail);
      end
   endfunction

   initial begin
      fail_count = 0; pending = 0; words_seen = 0; events_seen = 0;
   end

   always @(posedge clock) begin
      flow_event_type want;
      if (reset) begin
         jump_thr = RST_JUMP_THRESHOLD;     early_lim    = RST_EARLY_PACKET_LIMIT;
         stall_us = RST_STALL_TIME_US;      reorder_us   = RST_REORDER_WINDOW_US;
         gap_reset = RST_GAP_RESET_US;      flight_segs  = RST_FLIGHT_SEGMENTS;
         reorder_segs = RST_REORDER_SEGMENTS;
         forget_flow();
         expected_events.delete();
      end else begin
         // events first: one taken now was caused by an earlier word
         if (rsp.valid && rsp.ready) begin
            events_seen++;
            if (expected_events.size() == 0) begin
               report("event with none expected, kind", rsp.event_kind, 0);
            end else begin
               want = expected_events.pop_front();
               if (rsp.event_kind != want.kind)   report("kind", rsp.event_kind, want.kind);
               if (rsp.event_flow != want.flow)   report("flow", rsp.event_flow, want.flow);
               if (rsp.event_seq != want.seq)     report("seq", rsp.event_seq, want.seq);
               if (rsp.event_time_us != want.t_us)
                  report("time", rsp.event_time_us, want.t_us);
               if (rsp.event_count != want.count) report("count", rsp.event_count, want.count);
               if (rsp.last_event != want.last)   report("last", rsp.last_event, want.last);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_JUMP_THRESHOLD:     jump_thr     = csr_wdata[31:0];
               CSR_EARLY_PACKET_LIMIT: early_lim    = csr_wdata[7:0];
               CSR_STALL_TIME_US:      stall_us     = csr_wdata;
               CSR_REORDER_WINDOW_US:  reorder_us   = csr_wdata;
               CSR_GAP_RESET_US:       gap_reset    = csr_wdata;
               CSR_FLIGHT_SEGMENTS:    flight_segs  = csr_wdata[7:0];
               CSR_REORDER_SEGMENTS:   reorder_segs = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            words_seen++;
            classify_word(req.op, req.flow_key, req.seq_begin, req.seq_finish,
                          req.payload_len, req.ack_number, req.arrival_us);
         end
      end
      pending = expected_events.size();
   end

endmodule
`default_nettype wire

// File: test/tcp_flow_loss_classifier_unit_tb.sv
// Top of the flow loss classifier bench: clock, reset, packet stimulus, event sink
// and verdict. Depends on tfl_pkg, tfl_channels, tfl_flow_checker and the block.
`timescale 1ns / 1ps
`default_nettype none
module tcp_flow_loss_classifier_unit_tb;
   import tfl_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int  fail_count, pending, words_seen, events_seen;
   int  words_sent = 0;
   bit  calm = 0;        // no idling on either side while set
   bit  hold_long = 0;   // asks the event sink for one long hold-off

   tfl_req_if req_chan ();
   tfl_rsp_if rsp_chan ();

   tcp_flow_loss_classifier_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tfl_flow_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .words_seen  (words_seen),
      .events_seen (events_seen)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop: far beyond the slowest legal run (64 events per word, each held off by the longest random sink stall).
   initial begin
      #30_000_000;
      $display("timeout with %0d events outstanding", pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------- word sender
   // Optional idle gap, then present the word and hold it until taken. Valid is
   // left high on return so back-to-back words never drop it within one step.
   task automatic send_word(logic op, logic [31:0] key, logic [31:0] sb, logic [31:0] sf,
                            logic [15:0] plen, logic [31:0] ack, logic [47:0] tm);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.op          <= op;
      req_chan.flow_key    <= key;
      req_chan.seq_begin   <= sb;
      req_chan.seq_finish  <= sf;
      req_chan.payload_len <= plen;
      req_chan.ack_number  <= ack;
      req_chan.arrival_us  <= tm;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
   endtask

   task automatic flush_trace();
      send_word(1'b1, $urandom, $urandom, $urandom, 16'($urandom), $urandom,
                {16'($urandom), 32'($urandom)});
   endtask

   // Wait until every predicted event is out, then let a silent word drain
   // (divider pass plus compare and commit stages).
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic load_registers(logic [31:0] jt, logic [7:0] epl, logic [47:0] stall,
                                 logic [47:0] rwin, logic [47:0] greset,
                                 logic [7:0] flight, logic [7:0] rseg);
      csr_we <= 1'b1;
      csr_index <= CSR_JUMP_THRESHOLD;     csr_wdata <= 48'(jt);     @(posedge clock);
      csr_index <= CSR_EARLY_PACKET_LIMIT; csr_wdata <= 48'(epl);    @(posedge clock);
      csr_index <= CSR_STALL_TIME_US;      csr_wdata <= stall;       @(posedge clock);
      csr_index <= CSR_REORDER_WINDOW_US;  csr_wdata <= rwin;        @(posedge clock);
      csr_index <= CSR_GAP_RESET_US;       csr_wdata <= greset;      @(posedge clock);
      csr_index <= CSR_FLIGHT_SEGMENTS;    csr_wdata <= 48'(flight); @(posedge clock);
      csr_index <= CSR_REORDER_SEGMENTS;   csr_wdata <= 48'(rseg);   @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // One flow of mostly well-formed traffic with random content: in-order runs,
   // holes, early segments, stalls (the ack left unchanged at random), retransmits,
   // time going backwards, zero-length words and some plain noise.
   task automatic play_flow(int words);
      logic [31:0] key, seq, ack, sb, sf;
      logic [15:0] len, plen;
      logic [47:0] tm;
      int pick, k;
      key = $urandom;
      seq = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 20000);
      ack = $urandom;
      len = 16'($urandom_range(1, 1460));
      tm  = {16'($urandom_range(0, 3)), 32'($urandom)};
      for (int w = 0; w < words; w++) begin
         pick = $urandom_range(0, 19);
         tm   = tm + 48'($urandom_range(1, 60000));
         plen = len;
         if ($urandom_range(0, 1) != 0) ack = ack + len;
         case (pick)
            10, 11, 12: begin
               k  = (pick == 12 && $urandom_range(0, 2) == 0) ? $urandom_range(40, 90)
                                                             : $urandom_range(1, 6);
               sb = seq + 32'(k) * len;
               sf = sb + len;
               seq = sf;
            end
            13, 14: begin
               sb = seq - 32'($urandom_range(1, 5)) * len;
               sf = sb + len;
            end
            15: begin
               tm = tm + 48'($urandom_range(900_000, 3_000_000));
               sb = seq; sf = seq + len; seq = sf;
            end
            16: begin
               sb = seq - len; sf = seq;
            end
            17: begin
               sb = $urandom; sf = $urandom; plen = 16'($urandom); ack = $urandom;
            end
            18: begin
               tm = tm - 48'($urandom_range(1, 200_000));
               sb = seq; sf = seq + len; seq = sf;
            end
            19: begin
               plen = '0; sb = seq; sf = seq;
            end
            default: begin
               sb = seq; sf = seq + len; seq = sf;
            end
         endcase
         send_word(1'b0, key, sb, sf, plen, ack, tm);
      end
   endtask

   task automatic random_phase(int target);
      int stop_at;
      stop_at = words_sent + target;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) flush_trace();
         else play_flow($urandom_range(4, 16));
      end
   endtask

   // ---------------------------------------------------------------- event sink
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_long) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_long = 0;
         end
         stall = calm ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   // ---------------------------------------------------------------- main sequence
   initial begin
      logic [31:0] dk;
      logic [47:0] t;
      req_chan.valid <= 1'b0;   req_chan.op <= 1'b0;
      req_chan.flow_key <= '0;  req_chan.seq_begin <= '0;  req_chan.seq_finish <= '0;
      req_chan.payload_len <= '0; req_chan.ack_number <= '0; req_chan.arrival_us <= '0;
      csr_we <= 1'b0; csr_index <= '0; csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, default registers. Sequence numbers kept small so the
      // early-packet rule stays out of the way.
      dk = 32'hFFFF_FFFF;
      t  = 48'd0;
      flush_trace();                                            // empty flush, count 0
      send_word(1'b0, dk, 32'd0, 32'd100, 16'd0, 32'hFFFF_FFFF, t);  // first packet
      send_word(1'b0, dk, 32'd100, 32'd200, 16'd0, 32'd5, t + 10);
      send_word(1'b0, dk, 32'd500, 32'd600, 16'd0, 32'd6, t + 20);   // hole, no guess yet
      send_word(1'b0, dk, 32'd600, 32'd700, 16'd100, 32'd7, t + 30);
      send_word(1'b0, dk, 32'd10700, 32'd10800, 16'd100, 32'd8, t + 40); // hole past limit
      send_word(1'b0, dk, 32'd11000, 32'd11100, 16'd100, 32'd9, t + 50); // small hole
      send_word(1'b0, dk, 32'd11100, 32'd11200, 16'd100, 32'd9, t + 2_000_050); // stall
      send_word(1'b0, dk, 32'd10000, 32'd10100, 16'd100, 32'd9, t + 2_000_060); // far early
      send_word(1'b0, dk, 32'd11000, 32'd11100, 16'd100, 32'd9, t + 2_000_070); // early again
      send_word(1'b0, dk, 32'd11200, 32'd11300, 16'd100, 32'd9, t + 2_000_080);
      send_word(1'b0, dk, 32'd11100, 32'd11200, 16'd100, 32'd9, t + 2_000_090); // tolerated
      send_word(1'b0, dk, 32'd11300, 32'd11400, 16'd100, 32'd9,
                t + 48'd5_000_000_000);                          // gap counts as zero
      send_word(1'b0, dk, 32'd11400, 32'd11500, 16'd100, 32'd9, 48'd10); // time backwards
      send_word(1'b0, dk, 32'd50000, 32'd50100, 16'd100, 32'd9, 48'd20); // big jump
      send_word(1'b0, dk, 32'd11500, 32'd11600, 16'd100, 32'd9, 48'd30);
      send_word(1'b0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0, 48'd0);   // flow change
      send_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);              // all ones
      send_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF,
                32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      flush_trace();
      settle();

      // Defaults, random traffic, with an unbroken burst into a long sink hold-off
      random_phase(25);
      settle();
      calm = 1;
      hold_long = 1;
      play_flow(14);
      calm = 0;
      settle();

      // Extreme settings, one way
      load_registers(32'hFFFF_FFFF, 8'd255, 48'd0, 48'hFFFF_FFFF_FFFF,
                     48'hFFFF_FFFF_FFFF, 8'd1, 8'd255);
      random_phase(36);
      settle();

      // Extreme settings, the other way
      load_registers(32'd0, 8'd0, 48'hFFFF_FFFF_FFFF, 48'd0, 48'd0, 8'd255, 8'd1);
      random_phase(36);
      settle();

      // Middling settings
      load_registers(32'($urandom_range(3000, 30000)), 8'd2, 48'd500_000, 48'd300_000,
                     48'd2_000_000_000, 8'd2, 8'd4);
      random_phase(36);
      flush_trace();
      settle();

      $display("covered %0d words and %0d events over defaults and three register sets,",
               words_seen, events_seen);
      $display("with holes past the event limit, stalls, reordering and a long sink hold-off");
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d events never seen", fail_count, pending);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/tfl_pkg.sv
rtl/tfl_channels.sv
rtl/tfl_datapath.sv
rtl/tfl_controller.sv
rtl/tcp_flow_loss_classifier_unit.sv
test/tfl_flow_checker.sv
test/tcp_flow_loss_classifier_unit_tb.sv
